FILE: design/psd3_pkg.sv
// Shared widths, register indexes and sideband types for the point-to-segment distance core.
package psd3_pkg;

  localparam int CoordW = 32;   // input coordinate width
  localparam int DiffW  = 33;   // coordinate difference width
  localparam int ProdW  = 66;   // product of two differences
  localparam int SumW   = 68;   // sum of three products, dot, squared length
  localparam int NumW   = 136;  // dot squared
  localparam int RootW  = 34;   // integer square root of a SumW-bit value
  localparam int DistW  = 33;   // delivered distance width
  localparam int IdxW   = 3;

  typedef logic [IdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_START_X = 3'd0;
  localparam cfg_idx_t REG_START_Y = 3'd1;
  localparam cfg_idx_t REG_START_Z = 3'd2;
  localparam cfg_idx_t REG_END_X   = 3'd3;
  localparam cfg_idx_t REG_END_Y   = 3'd4;
  localparam cfg_idx_t REG_END_Z   = 3'd5;

  localparam logic [CoordW-1:0] END_Z_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    PART_INTERIOR = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2,
    PART_DEGEN    = 2'd3
  } part_t;

  // Travels alongside the divider: squared distance to correct and the nearest part.
  typedef struct packed {
    logic [SumW-1:0] base;
    part_t           part;
  } side_t;

endpackage

FILE: design/psd3_div.sv
// Pipelined restoring divider: one quotient bit per stage, floor and remainder flag.
module psd3_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [psd3_pkg::NumW-1:0]     num,
  input  logic [psd3_pkg::SumW-1:0]     den,
  input  psd3_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [psd3_pkg::SumW-1:0]     quo,
  output logic                          rem_nz,
  output psd3_pkg::side_t               out_side
);

  localparam int SW    = psd3_pkg::SumW;
  localparam int Steps = psd3_pkg::SumW;

  typedef struct packed {
    logic [SW-1:0]   rem;
    logic [SW-1:0]   low;
    logic [SW-1:0]   quo;
    logic [SW-1:0]   den;
    psd3_pkg::side_t side;
  } div_stage_t;

  function automatic div_stage_t div_step(div_stage_t s);
    logic [SW:0] r2;
    logic [SW:0] diff;
    div_stage_t  o;
    r2   = {s.rem, s.low[SW-1]};
    diff = r2 - {1'b0, s.den};
    o     = s;
    o.low = {s.low[SW-2:0], 1'b0};
    if (r2 >= {1'b0, s.den}) begin
      o.rem = diff[SW-1:0];
      o.quo = {s.quo[SW-2:0], 1'b1};
    end else begin
      o.rem = r2[SW-1:0];
      o.quo = {s.quo[SW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [Steps:0] vld_r;
  div_stage_t     stg_r [0:Steps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Steps-1:0], in_valid};
    end
  end

  // Upper half of the numerator is already below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].rem  <= num[psd3_pkg::NumW-1:SW];
      stg_r[0].low  <= num[SW-1:0];
      stg_r[0].quo  <= '0;
      stg_r[0].den  <= den;
      stg_r[0].side <= in_side;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= div_step(stg_r[k]);
      end
    end
  end

  assign out_valid = vld_r[Steps];
  assign quo       = stg_r[Steps].quo;
  assign rem_nz    = |stg_r[Steps].rem;
  assign out_side  = stg_r[Steps].side;

endmodule

FILE: design/psd3_sqrt.sv
// Pipelined integer square root, rounded down, one root bit per stage.
module psd3_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [psd3_pkg::SumW-1:0]     rad,
  input  psd3_pkg::part_t               in_part,
  output logic                          out_valid,
  output logic [psd3_pkg::RootW-1:0]    root,
  output psd3_pkg::part_t               out_part
);

  localparam int SW    = psd3_pkg::SumW;
  localparam int RW    = psd3_pkg::RootW;
  localparam int Steps = psd3_pkg::RootW;

  typedef struct packed {
    logic [SW-1:0]   x;
    logic [RW+2:0]   rem;
    logic [RW-1:0]   root;
    psd3_pkg::part_t part;
  } sqrt_stage_t;

  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t s);
    logic [RW+2:0] r4;
    logic [RW+2:0] trial;
    sqrt_stage_t   o;
    r4    = {s.rem[RW:0], s.x[SW-1:SW-2]};
    trial = {1'b0, s.root, 2'b01};
    o     = s;
    o.x   = {s.x[SW-3:0], 2'b00};
    if (r4 >= trial) begin
      o.rem  = r4 - trial;
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = r4;
      o.root = {s.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [Steps:0] vld_r;
  sqrt_stage_t    stg_r [0:Steps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Steps-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].x    <= rad;
      stg_r[0].rem  <= '0;
      stg_r[0].root <= '0;
      stg_r[0].part <= in_part;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= sqrt_step(stg_r[k]);
      end
    end
  end

  assign out_valid = vld_r[Steps];
  assign root      = stg_r[Steps].root;
  assign out_part  = stg_r[Steps].part;

endmodule

FILE: design/point_segment_distance_3d_core.sv
// Top level: distance from a stream of 3D points to a configured segment.
//
// Input channel in_valid/in_stall carries one query point (signed Q16.16) per
// request; the result channel out_valid/out_stall returns its distance
// (unsigned Q17.16, rounded down) and which part of the segment is nearest.
// The segment endpoints are six registers written through cfg_we, cfg_index
// and cfg_data; write them only while no request is in flight.
// An accepted request passes the stages below, then the output register.
// One request per cycle while in_stall is low. Five arithmetic stages are
// followed by a 68-stage divider (one quotient bit per stage, needed for the
// perpendicular case) and a 34-stage square root (one root bit per stage).
// Reset (rst_n low, synchronous) empties the pipeline and loads the segment
// from the origin to (0, 0, 1.0).
// While the output register holds an untaken result and out_stall is high,
// the pipeline keeps advancing only if its last stage is empty; otherwise
// everything holds and in_stall rises. Nothing is dropped or repeated.
module point_segment_distance_3d_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  psd3_pkg::cfg_idx_t             cfg_index,
  input  logic [psd3_pkg::CoordW-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [psd3_pkg::CoordW-1:0] in_query_x,
  input  logic signed [psd3_pkg::CoordW-1:0] in_query_y,
  input  logic signed [psd3_pkg::CoordW-1:0] in_query_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psd3_pkg::DistW-1:0]     out_distance,
  output logic [1:0]                     out_nearest_part
);

  localparam int CW = psd3_pkg::CoordW;
  localparam int DW = psd3_pkg::DiffW;
  localparam int PW = psd3_pkg::ProdW;
  localparam int SW = psd3_pkg::SumW;
  localparam int HW = psd3_pkg::SumW / 2;

  // ---------------- configuration ----------------
  logic [CW-1:0] seg_start_r [3];
  logic [CW-1:0] seg_end_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_start_r[0] <= '0;
      seg_start_r[1] <= '0;
      seg_start_r[2] <= '0;
      seg_end_r[0]   <= '0;
      seg_end_r[1]   <= '0;
      seg_end_r[2]   <= psd3_pkg::END_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psd3_pkg::REG_START_X: seg_start_r[0] <= cfg_data;
        psd3_pkg::REG_START_Y: seg_start_r[1] <= cfg_data;
        psd3_pkg::REG_START_Z: seg_start_r[2] <= cfg_data;
        psd3_pkg::REG_END_X:   seg_end_r[0]   <= cfg_data;
        psd3_pkg::REG_END_Y:   seg_end_r[1]   <= cfg_data;
        psd3_pkg::REG_END_Z:   seg_end_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic out_valid_r;
  logic sq_valid;
  logic out_load;
  logic en;

  assign out_load = !out_valid_r || !out_stall;
  assign en       = out_load || !sq_valid;
  assign in_stall = !en;

  logic [CW-1:0] qry [3];
  assign qry[0] = in_query_x;
  assign qry[1] = in_query_y;
  assign qry[2] = in_query_z;

  // ---------------- stage 1: differences ----------------
  logic [4:0]           vld_r;
  logic signed [DW-1:0] v1_r [3];
  logic signed [DW-1:0] h1_r [3];
  logic signed [DW-1:0] g1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid && !in_stall};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= $signed({seg_end_r[i][CW-1], seg_end_r[i]})
                 - $signed({seg_start_r[i][CW-1], seg_start_r[i]});
        h1_r[i] <= $signed({qry[i][CW-1], qry[i]})
                 - $signed({seg_start_r[i][CW-1], seg_start_r[i]});
        g1_r[i] <= $signed({qry[i][CW-1], qry[i]})
                 - $signed({seg_end_r[i][CW-1], seg_end_r[i]});
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PW-1:0] vv2_r [3];
  logic signed [PW-1:0] hh2_r [3];
  logic signed [PW-1:0] gg2_r [3];
  logic signed [PW-1:0] vh2_r [3];
  logic                 degen2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vv2_r[i] <= v1_r[i] * v1_r[i];
        hh2_r[i] <= h1_r[i] * h1_r[i];
        gg2_r[i] <= g1_r[i] * g1_r[i];
        vh2_r[i] <= v1_r[i] * h1_r[i];
      end
      degen2_r <= (v1_r[0] == '0) && (v1_r[1] == '0) && (v1_r[2] == '0);
    end
  end

  // ---------------- stage 3: sums ----------------
  logic [SW-1:0]        len3_r;
  logic [SW-1:0]        hsum3_r;
  logic [SW-1:0]        gsum3_r;
  logic signed [SW-1:0] dot3_r;
  logic                 degen3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      len3_r  <= {2'b00, vv2_r[0]} + {2'b00, vv2_r[1]} + {2'b00, vv2_r[2]};
      hsum3_r <= {2'b00, hh2_r[0]} + {2'b00, hh2_r[1]} + {2'b00, hh2_r[2]};
      gsum3_r <= {2'b00, gg2_r[0]} + {2'b00, gg2_r[1]} + {2'b00, gg2_r[2]};
      dot3_r  <= {{2{vh2_r[0][PW-1]}}, vh2_r[0]}
               + {{2{vh2_r[1][PW-1]}}, vh2_r[1]}
               + {{2{vh2_r[2][PW-1]}}, vh2_r[2]};
      degen3_r <= degen2_r;
    end
  end

  // ---------------- stage 4: classify ----------------
  logic            dot_le0;
  logic            dot_ge_len;
  psd3_pkg::side_t side4_nxt;
  logic [SW-1:0]   den4_nxt;
  logic [SW-1:0]   dot4_nxt;
  psd3_pkg::side_t side4_r;
  logic [SW-1:0]   den4_r;
  logic [SW-1:0]   dot4_r;

  assign dot_le0    = dot3_r[SW-1] || (dot3_r == '0);
  assign dot_ge_len = !dot3_r[SW-1] && (dot3_r >= len3_r);

  // Endpoint cases divide zero by one, so the correction vanishes.
  always_comb begin
    den4_nxt = {{(SW-1){1'b0}}, 1'b1};
    dot4_nxt = '0;
    if (degen3_r) begin
      side4_nxt = '{base: gsum3_r, part: psd3_pkg::PART_DEGEN};
    end else if (dot_le0) begin
      side4_nxt = '{base: hsum3_r, part: psd3_pkg::PART_START};
    end else if (dot_ge_len) begin
      side4_nxt = '{base: gsum3_r, part: psd3_pkg::PART_END};
    end else begin
      side4_nxt = '{base: hsum3_r, part: psd3_pkg::PART_INTERIOR};
      den4_nxt  = len3_r;
      dot4_nxt  = dot3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side4_nxt;
      den4_r  <= den4_nxt;
      dot4_r  <= dot4_nxt;
    end
  end

  // ---------------- stage 5: dot squared, partial products ----------------
  logic [SW-1:0]   aa5_r;
  logic [SW-1:0]   ab5_r;
  logic [SW-1:0]   bb5_r;
  psd3_pkg::side_t side5_r;
  logic [SW-1:0]   den5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aa5_r   <= dot4_r[SW-1:HW] * dot4_r[SW-1:HW];
      ab5_r   <= dot4_r[SW-1:HW] * dot4_r[HW-1:0];
      bb5_r   <= dot4_r[HW-1:0] * dot4_r[HW-1:0];
      side5_r <= side4_r;
      den5_r  <= den4_r;
    end
  end

  logic [psd3_pkg::NumW-1:0] dsq;

  assign dsq = {aa5_r, {SW{1'b0}}}
             + {{(HW-1){1'b0}}, ab5_r, {(HW+1){1'b0}}}
             + {{SW{1'b0}}, bb5_r};

  // ---------------- divider: ceil(dot^2 / len) ----------------
  logic            dv_valid;
  logic [SW-1:0]   dv_quo;
  logic            dv_rem_nz;
  psd3_pkg::side_t dv_side;

  psd3_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r[4]),
    .num       (dsq),
    .den       (den5_r),
    .in_side   (side5_r),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .rem_nz    (dv_rem_nz),
    .out_side  (dv_side)
  );

  // floor(|h|^2 - dot^2/len) = |h|^2 - ceil(dot^2/len)
  logic [SW-1:0] rad;
  assign rad = dv_side.base + ~dv_quo + {{(SW-1){1'b0}}, !dv_rem_nz};

  // ---------------- square root ----------------
  logic [psd3_pkg::RootW-1:0] sq_root;
  psd3_pkg::part_t            sq_part;

  psd3_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .rad       (rad),
    .in_part   (dv_side.part),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_part  (sq_part)
  );

  // ---------------- output register ----------------
  logic [psd3_pkg::DistW-1:0] dist_r;
  psd3_pkg::part_t            part_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dist_r <= sq_root[psd3_pkg::DistW-1:0];
      part_r <= sq_part;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance     = dist_r;
  assign out_nearest_part = part_r;

endmodule

FILE: bench/point_segment_distance_3d_core_tb.sv
// Testbench for the point-to-segment distance core: directed table, extreme and degenerate segments, random requests.
module point_segment_distance_3d_core_tb;

  typedef struct {
    logic [psd3_pkg::CoordW-1:0] qx, qy, qz;
    logic [psd3_pkg::DistW-1:0] distance;
    psd3_pkg::part_t part;
  } dist_rec_t;

  typedef struct {
    logic [psd3_pkg::CoordW-1:0] qx, qy, qz;
    bit known;
    logic [psd3_pkg::DistW-1:0] distance;
    psd3_pkg::part_t part;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  psd3_pkg::cfg_idx_t cfg_index = psd3_pkg::REG_START_X;
  logic [psd3_pkg::CoordW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [psd3_pkg::CoordW-1:0] in_query_x = '0, in_query_y = '0, in_query_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [psd3_pkg::DistW-1:0] out_distance;
  logic [1:0] out_nearest_part;

  logic [psd3_pkg::CoordW-1:0] seg_reg [6];
  dist_rec_t pending_dist [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  bit press_go = 1'b0;

  point_segment_distance_3d_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200000000;
    $display("point_segment_distance_3d_core: mismatch");
    $finish;
  end

  function automatic logic [psd3_pkg::RootW-1:0] isqrt(logic [psd3_pkg::NumW-1:0] x);
    logic [psd3_pkg::RootW-1:0] r;
    logic [psd3_pkg::RootW-1:0] c;
    r = '0;
    for (int b = psd3_pkg::RootW - 1; b >= 0; b--) begin
      c = r | (psd3_pkg::RootW'(1) << b);
      if ({{(psd3_pkg::NumW-2*psd3_pkg::RootW){1'b0}},
           c * {{psd3_pkg::RootW{1'b0}}, c}} <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [psd3_pkg::NumW-1:0] dist_sq(
      logic signed [psd3_pkg::DiffW:0] a[3], logic signed [psd3_pkg::DiffW:0] b[3]);
    logic signed [psd3_pkg::NumW-1:0] d;
    logic [psd3_pkg::NumW-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      d = a[i] - b[i];
      acc += d * d;
    end
    return acc;
  endfunction

  // Exact nearest-part decision on integer dot products, no division in the clamps.
  task automatic predict_distance(input logic [psd3_pkg::CoordW-1:0] qx, qy, qz,
                                  output logic [psd3_pkg::DistW-1:0] distance,
                                  output psd3_pkg::part_t part);
    logic signed [psd3_pkg::DiffW:0] q[3], s[3], e[3];
    logic signed [psd3_pkg::NumW-1:0] v, h, dot, len2, hh, num;
    q[0] = $signed(qx); q[1] = $signed(qy); q[2] = $signed(qz);
    for (int i = 0; i < 3; i++) begin
      s[i] = $signed(seg_reg[i]);
      e[i] = $signed(seg_reg[i+3]);
    end
    dot = 0; len2 = 0; hh = 0;
    for (int i = 0; i < 3; i++) begin
      v = e[i] - s[i];
      h = q[i] - s[i];
      dot += v * h;
      len2 += v * v;
      hh += h * h;
    end
    if (len2 == 0) begin
      distance = psd3_pkg::DistW'(isqrt(dist_sq(q, e)));
      part = psd3_pkg::PART_DEGEN;
    end else if (dot <= 0) begin
      distance = psd3_pkg::DistW'(isqrt(dist_sq(q, s)));
      part = psd3_pkg::PART_START;
    end else if (dot >= len2) begin
      distance = psd3_pkg::DistW'(isqrt(dist_sq(q, e)));
      part = psd3_pkg::PART_END;
    end else begin
      num = (hh * len2 - dot * dot) / len2;
      distance = psd3_pkg::DistW'(isqrt(num));
      part = psd3_pkg::PART_INTERIOR;
    end
  endtask

  // Drop the write enable for a cycle after each write.
  task automatic write_reg(input psd3_pkg::cfg_idx_t idx,
                           input logic [psd3_pkg::CoordW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= psd3_pkg::REG_END_Z) seg_reg[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_segment(input logic [psd3_pkg::CoordW-1:0] sx, sy, sz, ex, ey, ez);
    write_reg(psd3_pkg::REG_START_X, sx);
    write_reg(psd3_pkg::REG_START_Y, sy);
    write_reg(psd3_pkg::REG_START_Z, sz);
    write_reg(psd3_pkg::REG_END_X, ex);
    write_reg(psd3_pkg::REG_END_Y, ey);
    write_reg(psd3_pkg::REG_END_Z, ez);
  endtask

  // Offer one request; queue its expectation at the accepting edge. Valid stays high
  // after acceptance so that the next request can follow at once.
  task automatic send_query(input logic [psd3_pkg::CoordW-1:0] qx, qy, qz, input bit known,
                            input logic [psd3_pkg::DistW-1:0] kd,
                            input psd3_pkg::part_t kp);
    dist_rec_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_query_x <= qx; in_query_y <= qy; in_query_z <= qz;
    r.qx = qx; r.qy = qy; r.qz = qz;
    if (known) begin
      r.distance = kd; r.part = kp;
    end else predict_distance(qx, qy, qz, r.distance, r.part);
    do @(posedge clk); while (in_stall);
    pending_dist.push_back(r);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [psd3_pkg::CoordW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return psd3_pkg::CoordW'($signed($urandom_range(2000000)) - 1000000);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return psd3_pkg::CoordW'($signed($urandom_range(400)) - 200) <<< 16;
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    dist_rec_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", out_distance,
                                       out_nearest_part);
      end else begin
        r = pending_dist.pop_front();
        if (out_distance !== r.distance || out_nearest_part !== r.part) begin
          mismatches++;
          if (mismatches <= 10)
            $display("query %h %h %h: expected %0d/%0d, got %0d/%0d", r.qx, r.qy, r.qz,
                     r.distance, r.part, out_distance, out_nearest_part);
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    wait (press_go);
    repeat (5) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  probe_row_t probes [] = '{
    '{32'h0, 32'h0, 32'h0, 1'b1, 33'd0, psd3_pkg::PART_START},
    '{32'h0, 32'h0, 32'h0001_0000, 1'b1, 33'd0, psd3_pkg::PART_END},
    '{32'h0, 32'h0, 32'h0000_8000, 1'b1, 33'd0, psd3_pkg::PART_INTERIOR},
    '{32'h0003_0000, 32'h0004_0000, 32'h0000_8000, 1'b1, 33'h5_0000,
      psd3_pkg::PART_INTERIOR},
    '{32'h0, 32'h0, 32'hFFFF_0000, 1'b1, 33'h1_0000, psd3_pkg::PART_START},
    '{32'h0, 32'h0, 32'h0003_0000, 1'b1, 33'h2_0000, psd3_pkg::PART_END},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, psd3_pkg::PART_START},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, psd3_pkg::PART_START},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_4000, 1'b0, '0, psd3_pkg::PART_START},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_FFFF, 1'b0, '0, psd3_pkg::PART_START}
  };

  initial begin
    seg_reg[0] = '0; seg_reg[1] = '0; seg_reg[2] = '0;
    seg_reg[3] = '0; seg_reg[4] = '0; seg_reg[5] = psd3_pkg::END_Z_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i])
      send_query(probes[i].qx, probes[i].qy, probes[i].qz, probes[i].known,
                 probes[i].distance, probes[i].part);
    drain();

    // Extreme segment, then a degenerate segment at one corner, queried from both corners.
    load_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    foreach (probes[i]) send_query(probes[i].qx, probes[i].qy, probes[i].qz, 0, '0,
                                   psd3_pkg::PART_START);
    drain();
    load_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0, psd3_pkg::PART_START);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 33'd0,
               psd3_pkg::PART_DEGEN);
    drain();
    write_reg(3'd7, 32'h1234_5678); // unmapped index: ignored

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 26 : phase == 1 ? 72 : 0;
      recv_idle_pct = phase == 0 ? 72 : phase == 1 ? 26 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        int m;
        m = $urandom_range(3);
        load_segment(rand_coord(m), rand_coord(m), rand_coord(m),
                     rand_coord(m), rand_coord(m), rand_coord(m));
        for (int k = 0; k < 52; k++) begin
          m = $urandom_range(3);
          send_query(rand_coord(m), rand_coord(m), rand_coord(m), 0, '0,
                     psd3_pkg::PART_START);
        end
        drain();
      end
    end

    // Back-to-back burst against a long receiver hold-off: fill the pipeline.
    begin
      int m;
      m = $urandom_range(3);
      load_segment(rand_coord(m), rand_coord(m), rand_coord(m),
                   rand_coord(m), rand_coord(m), rand_coord(m));
      press_go = 1'b1;
      for (int k = 0; k < 200; k++) begin
        m = $urandom_range(3);
        send_query(rand_coord(m), rand_coord(m), rand_coord(m), 0, '0,
                   psd3_pkg::PART_START);
      end
    end

    drain();
    if (mismatches == 0) $display("point_segment_distance_3d_core: match");
    else $display("point_segment_distance_3d_core: mismatch");
    $finish;
  end
endmodule
